>>> rtl/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg
// Shared types and codes for the SOCKS5 greeting and CONNECT request parser.
// ----------------------------------------------------------------------------
package shp_pkg;

    // Parser phase, one per expected byte position of the client stream
    typedef enum logic [3:0] {
        PH_GVER   = 4'd0,
        PH_GNUM   = 4'd1,
        PH_GMETH  = 4'd2,
        PH_RVER   = 4'd3,
        PH_RCMD   = 4'd4,
        PH_RRSV   = 4'd5,
        PH_RATYP  = 4'd6,
        PH_V4ADDR = 4'd7,
        PH_PORT   = 4'd8,
        PH_DLEN   = 4'd9,
        PH_DNAME  = 4'd10,
        PH_DONE   = 4'd11,
        PH_CLOSED = 4'd12
    } phase_t;

    // Input operation codes
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Result kinds
    localparam logic [2:0] KIND_METHOD_REPLY = 3'd0;
    localparam logic [2:0] KIND_CONNECT_V4   = 3'd1;
    localparam logic [2:0] KIND_DOMAIN_BYTE  = 3'd2;
    localparam logic [2:0] KIND_DOMAIN_PORT  = 3'd3;
    localparam logic [2:0] KIND_CLOSE        = 3'd4;

    // Error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_GREET_VER   = 3'd1;
    localparam logic [2:0] ERR_ZERO_METH   = 3'd2;
    localparam logic [2:0] ERR_REQ_VER     = 3'd3;
    localparam logic [2:0] ERR_COMMAND     = 3'd4;
    localparam logic [2:0] ERR_RESERVED    = 3'd5;
    localparam logic [2:0] ERR_ADDR_TYPE   = 3'd6;
    localparam logic [2:0] ERR_IPV6        = 3'd7;

    // Protocol byte values
    localparam logic [7:0] SOCKS_VERSION = 8'd5;
    localparam logic [7:0] CMD_CONNECT   = 8'd1;
    localparam logic [7:0] RSV_ZERO      = 8'd0;
    localparam logic [7:0] ATYP_IPV4     = 8'd1;
    localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
    localparam logic [7:0] ATYP_IPV6     = 8'd4;

    // Stored address type
    localparam logic [1:0] AT_NONE   = 2'd0;
    localparam logic [1:0] AT_IPV4   = 2'd1;
    localparam logic [1:0] AT_DOMAIN = 2'd3;

    // Byte counts
    localparam logic [7:0] IPV4_ADDR_BYTES = 8'd4;
    localparam logic [7:0] PORT_BYTES      = 8'd2;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  error_code;
        logic [31:0] target_address;
        logic [15:0] target_port;
        logic [7:0]  name_byte;
        logic        last;
    } result_t;

endpackage

>>> rtl/shp_parser.sv
// ----------------------------------------------------------------------------
// shp_parser
// Parser state and the single-pass decode of one client byte into at most
// one result.
// ----------------------------------------------------------------------------
module shp_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                op,
    input  logic [7:0]          data_byte,
    output logic                res_valid,
    output shp_pkg::result_t    res
);
    import shp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [1:0]  address_type_reg, address_type_next;
    logic [31:0] address_shift_reg, address_shift_next;
    logic [15:0] port_shift_reg, port_shift_next;

    logic [7:0]  bytes_dec;
    logic [15:0] port_shifted;

    assign bytes_dec    = bytes_left_reg - 8'd1;
    assign port_shifted = {port_shift_reg[7:0], data_byte};

    // Next state
    always_comb
    begin
        phase_next         = phase_reg;
        bytes_left_next    = bytes_left_reg;
        address_type_next  = address_type_reg;
        address_shift_next = address_shift_reg;
        port_shift_next    = port_shift_reg;
        if (op == OP_START) begin
            phase_next         = PH_GVER;
            bytes_left_next    = 8'd0;
            address_type_next  = AT_NONE;
            address_shift_next = 32'd0;
            port_shift_next    = 16'd0;
        end else begin
            unique case (phase_reg)
                PH_GVER:
                    phase_next = (data_byte == SOCKS_VERSION) ? PH_GNUM : PH_CLOSED;
                PH_GNUM:
                begin
                    if (data_byte == 8'd0) begin
                        phase_next = PH_CLOSED;
                    end else begin
                        bytes_left_next = data_byte;
                        phase_next      = PH_GMETH;
                    end
                end
                PH_GMETH:
                begin
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 8'd0) begin
                        phase_next = PH_RVER;
                    end
                end
                PH_RVER:
                    phase_next = (data_byte == SOCKS_VERSION) ? PH_RCMD : PH_CLOSED;
                PH_RCMD:
                    phase_next = (data_byte == CMD_CONNECT) ? PH_RRSV : PH_CLOSED;
                PH_RRSV:
                    phase_next = (data_byte == RSV_ZERO) ? PH_RATYP : PH_CLOSED;
                PH_RATYP:
                begin
                    if (data_byte == ATYP_IPV4) begin
                        address_type_next  = AT_IPV4;
                        address_shift_next = 32'd0;
                        bytes_left_next    = IPV4_ADDR_BYTES;
                        phase_next         = PH_V4ADDR;
                    end else if (data_byte == ATYP_DOMAIN) begin
                        address_type_next = AT_DOMAIN;
                        phase_next        = PH_DLEN;
                    end else begin
                        phase_next = PH_CLOSED;
                    end
                end
                PH_V4ADDR:
                begin
                    address_shift_next = {address_shift_reg[23:0], data_byte};
                    bytes_left_next    = bytes_dec;
                    if (bytes_dec == 8'd0) begin
                        port_shift_next = 16'd0;
                        bytes_left_next = PORT_BYTES;
                        phase_next      = PH_PORT;
                    end
                end
                PH_PORT:
                begin
                    port_shift_next = port_shifted;
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 8'd0) begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DLEN:
                begin
                    port_shift_next = 16'd0;
                    if (data_byte == 8'd0) begin
                        bytes_left_next = PORT_BYTES;
                        phase_next      = PH_PORT;
                    end else begin
                        bytes_left_next = data_byte;
                        phase_next      = PH_DNAME;
                    end
                end
                PH_DNAME:
                begin
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 8'd0) begin
                        bytes_left_next = PORT_BYTES;
                        phase_next      = PH_PORT;
                    end
                end
                PH_DONE, PH_CLOSED:
                    phase_next = phase_reg;
                default:
                    phase_next = phase_reg;
            endcase
        end
    end

    // Result for the current byte
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        if (op == OP_BYTE) begin
            unique case (phase_reg)
                PH_GVER:
                begin
                    if (data_byte != SOCKS_VERSION) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_CLOSE;
                        res.error_code = ERR_GREET_VER;
                    end
                end
                PH_GNUM:
                begin
                    if (data_byte == 8'd0) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_CLOSE;
                        res.error_code = ERR_ZERO_METH;
                    end
                end
                PH_GMETH:
                begin
                    if (bytes_dec == 8'd0) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_METHOD_REPLY;
                    end
                end
                PH_RVER:
                begin
                    if (data_byte != SOCKS_VERSION) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_CLOSE;
                        res.error_code = ERR_REQ_VER;
                    end
                end
                PH_RCMD:
                begin
                    if (data_byte != CMD_CONNECT) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_CLOSE;
                        res.error_code = ERR_COMMAND;
                    end
                end
                PH_RRSV:
                begin
                    if (data_byte != RSV_ZERO) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_CLOSE;
                        res.error_code = ERR_RESERVED;
                    end
                end
                PH_RATYP:
                begin
                    if (data_byte == ATYP_IPV6) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_CLOSE;
                        res.error_code = ERR_IPV6;
                    end else if (data_byte != ATYP_IPV4 && data_byte != ATYP_DOMAIN) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_CLOSE;
                        res.error_code = ERR_ADDR_TYPE;
                    end
                end
                PH_PORT:
                begin
                    if (bytes_dec == 8'd0) begin
                        res_valid       = 1'b1;
                        res.target_port = port_shifted;
                        if (address_type_reg == AT_IPV4) begin
                            res.kind           = KIND_CONNECT_V4;
                            res.target_address = address_shift_reg;
                        end else begin
                            res.kind = KIND_DOMAIN_PORT;
                        end
                    end
                end
                PH_DNAME:
                begin
                    res_valid     = 1'b1;
                    res.kind      = KIND_DOMAIN_BYTE;
                    res.name_byte = data_byte;
                    res.last      = (bytes_dec == 8'd0);
                end
                PH_V4ADDR, PH_DLEN, PH_DONE, PH_CLOSED:
                    res_valid = 1'b0;
                default:
                    res_valid = 1'b0;
            endcase
        end
    end

    // Advance state on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg         <= PH_GVER;
            bytes_left_reg    <= 8'd0;
            address_type_reg  <= AT_NONE;
            address_shift_reg <= 32'd0;
            port_shift_reg    <= 16'd0;
        end else if (step) begin
            phase_reg         <= phase_next;
            bytes_left_reg    <= bytes_left_next;
            address_type_reg  <= address_type_next;
            address_shift_reg <= address_shift_next;
            port_shift_reg    <= port_shift_next;
        end
    end

    // A closed session stays closed until a new session starts
    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_CLOSED && op == OP_BYTE) |=> phase_reg == PH_CLOSED)
        else $error("closed session reopened without a start");

    // Any close result moves the parser to the closed phase
    a_close_enters_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid && res.kind == KIND_CLOSE) |=> phase_reg == PH_CLOSED)
        else $error("close emitted but parser not closed");

    // Errors travel only with a close result
    a_err_with_close: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res.kind == KIND_CLOSE) == (res.error_code != ERR_NONE)))
        else $error("error code and kind disagree");

    // Port phase counts at most two bytes
    a_port_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PORT |-> (bytes_left_reg == 8'd1 || bytes_left_reg == PORT_BYTES))
        else $error("port byte count out of range");

endmodule

>>> rtl/shp_out_reg.sv
// ----------------------------------------------------------------------------
// shp_out_reg
// Result register: holds one request result until the consumer takes it.
// ----------------------------------------------------------------------------
module shp_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  shp_pkg::result_t    res,
    output logic                ready,
    output logic                out_valid,
    input  logic                out_stall,
    output shp_pkg::result_t    out_res
);
    import shp_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // Free when empty or being drained this cycle
    assign ready = !valid_reg || !out_stall;

    // Fill on a new result, drop when taken, hold otherwise
    always_comb
    begin
        if (load && ready) begin
            valid_next = 1'b1;
        end else if (!out_stall) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload loads only when a new result enters
    always_ff @(posedge clk)
    begin
        if (load && ready) begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

>>> rtl/socks5_handshake_parser_top.sv
// ----------------------------------------------------------------------------
// socks5_handshake_parser_top
// Pipeline: an accepted byte is held in the input register, decoded in one pass,
// and any result is loaded into the result register. Throughput: one byte per
// cycle; the two registers form a two-stage pipeline that stalls only on out_stall.
// Reset: rst_n clears both pipeline valids and puts the parser at the
// greeting version byte; op = 1 restarts the session without emitting.
// ----------------------------------------------------------------------------
module socks5_handshake_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [2:0]  error_code,
    output logic [31:0] target_address,
    output logic [15:0] target_port,
    output logic [7:0]  name_byte,
    output logic        last
);
    import shp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic       op_reg;
    logic [7:0] data_byte_reg;
    logic       accept;
    logic       advance;
    logic       step;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    // Input stage: take a byte whenever the register is empty or the held one moves on
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign step     = in_valid_reg && advance;

    always_comb
    begin
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            op_reg        <= op;
            data_byte_reg <= data_byte;
        end
    end

    // Decode one byte against the parser state
    shp_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .op        (op_reg),
        .data_byte (data_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Hold the result for the consumer
    shp_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res       (res),
        .ready     (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kind           = out_res.kind;
    assign error_code     = out_res.error_code;
    assign target_address = out_res.target_address;
    assign target_port    = out_res.target_port;
    assign name_byte      = out_res.name_byte;
    assign last           = out_res.last;

endmodule
